### hdl/scsa_pkg.sv
`default_nettype none
package scsa_pkg;

	localparam int NUM_CLASSES     = 64;
	localparam int SLOT_BASE_BYTES = 8;
	localparam int BLOCK_BYTES     = 4096;
	localparam int ARENA_BYTES     = 65536;

	localparam int SLOT_SHIFT  = $clog2(SLOT_BASE_BYTES);
	localparam int TOTAL_UNITS = ARENA_BYTES / SLOT_BASE_BYTES;
	localparam int BLOCK_UNITS = BLOCK_BYTES / SLOT_BASE_BYTES;
	localparam int MAX_SIZE    = NUM_CLASSES * SLOT_BASE_BYTES;

	localparam int CLS_W  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
	localparam int UNIT_W = $clog2(TOTAL_UNITS);
	localparam int CUR_W  = UNIT_W + 1;
	localparam int LINK_W = UNIT_W + 1;

	localparam logic [31:0] ARENA_BASE_RESET = 32'h0001_0000;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_IGNORED   = 3'd1;
	localparam logic [2:0] ST_TOO_LARGE = 3'd2;
	localparam logic [2:0] ST_OOM       = 3'd3;
	localparam logic [2:0] ST_BAD_ADDR  = 3'd4;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	typedef struct packed {
		logic        command;
		logic [15:0] size_bytes;
		logic [31:0] free_address;
	} scsa_in_t;

	typedef struct packed {
		logic [31:0] slot_address;
		logic [2:0]  status;
	} scsa_out_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic exec;
		logic link_rd;
		logic pop;
		logic take;
		logic hold;
		logic emit;
	} scsa_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic need_pop;
		logic out_free;
	} scsa_stat_t;

endpackage
`default_nettype wire

### hdl/scsa_ram.sv
`default_nettype none
module scsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

### hdl/scsa_ctrl.sv
`default_nettype none
module scsa_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire scsa_pkg::scsa_stat_t st,
	output scsa_pkg::scsa_cmd_t     cmd
);
	import scsa_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_POP  = 2'd2;
	localparam logic [1:0] S_EMIT = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		state_d  = state_q;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				if (st.need_pop) begin
					cmd.link_rd = 1'b1;
					state_d     = S_POP;
				end else if (st.out_free) begin
					cmd.take = 1'b1;
					state_d  = S_IDLE;
				end else begin
					cmd.hold = 1'b1;
					state_d  = S_EMIT;
				end
			end
			S_POP: begin
				cmd.pop = 1'b1;
				if (st.out_free) begin
					cmd.take = 1'b1;
					state_d  = S_IDLE;
				end else begin
					cmd.hold = 1'b1;
					state_d  = S_EMIT;
				end
			end
			S_EMIT: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

### hdl/scsa_datapath.sv
`default_nettype none
module scsa_datapath (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire scsa_pkg::scsa_in_t   in_data,
	input  wire logic                 cfg_we,
	input  wire logic [31:0]          cfg_wdata,
	input  wire scsa_pkg::scsa_cmd_t  cmd,
	output scsa_pkg::scsa_stat_t      st,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output scsa_pkg::scsa_out_t       out_data
);
	import scsa_pkg::*;

	logic [31:0]            base_q;
	scsa_in_t               req_q;
	logic [CLS_W-1:0]       cls_q;
	logic [NUM_CLASSES-1:0] nonempty_q;
	logic [NUM_CLASSES-1:0] carved_q;
	logic [CUR_W-1:0]       arena_q;
	logic                   out_valid_q;
	scsa_out_t              out_q;
	scsa_out_t              res_q;

	logic [15:0]      size_m1;
	logic [CLS_W-1:0] cls_in;

	logic [UNIT_W-1:0] head_rd;
	logic [CUR_W-1:0]  cur_rd;
	logic [CUR_W-1:0]  end_rd;
	logic [LINK_W-1:0] link_rd;

	logic              ignored, too_large, ne, carved;
	logic [CUR_W-1:0]  cur, blk_end;
	logic [CUR_W:0]    units, cur_next, arena_next;
	logic              need_block, oom;
	logic [31:0]       offset;
	logic              bad_addr;
	logic [UNIT_W-1:0] free_unit;
	logic [UNIT_W-1:0] slot;
	logic              alloc_go, alloc_bump, alloc_new, free_go;
	scsa_out_t         res;

	logic              head_we;
	logic [UNIT_W-1:0] head_wdata;
	logic              cur_we;
	logic [CUR_W-1:0]  cur_wdata;

	// class index is (size - 1) / slot size for any size from 1 to MAX_SIZE
	assign size_m1 = in_data.size_bytes - 16'd1;
	assign cls_in  = size_m1[SLOT_SHIFT+CLS_W-1:SLOT_SHIFT];

	always_comb begin
		ignored   = (req_q.command == CMD_FREE && req_q.free_address == 32'd0) ||
		            req_q.size_bytes == 16'd0;
		too_large = {1'b0, req_q.size_bytes} > 17'(MAX_SIZE);
		ne        = nonempty_q[cls_q];
		carved    = carved_q[cls_q];
		cur       = carved ? cur_rd : '0;
		blk_end   = carved ? end_rd : '0;
		units     = (CUR_W+1)'(cls_q) + 1'b1;
		cur_next  = {1'b0, cur} + units;
		need_block = cur_next > {1'b0, blk_end};
		arena_next = {1'b0, arena_q} + (CUR_W+1)'(BLOCK_UNITS);
		oom        = arena_next > (CUR_W+1)'(TOTAL_UNITS);

		offset    = req_q.free_address - base_q;
		bad_addr  = (req_q.free_address < base_q) || (offset >= 32'(ARENA_BYTES)) ||
		            (offset[SLOT_SHIFT-1:0] != '0);
		free_unit = offset[SLOT_SHIFT+UNIT_W-1:SLOT_SHIFT];

		st.need_pop = cmd.exec && req_q.command == CMD_ALLOC && !ignored && !too_large && ne;
		st.out_free = !out_valid_q || out_ready;

		alloc_go   = cmd.exec && req_q.command == CMD_ALLOC && !ignored && !too_large && !ne &&
		             !((CUR_W+1)'(units) > (CUR_W+1)'(BLOCK_UNITS));
		alloc_new  = alloc_go && need_block && !oom;
		alloc_bump = alloc_go && (!need_block || !oom);
		free_go    = cmd.exec && req_q.command == CMD_FREE && !ignored && !too_large && !bad_addr;

		slot = need_block ? arena_q[UNIT_W-1:0] : cur[UNIT_W-1:0];

		res.slot_address = 32'd0;
		priority if (cmd.pop) begin
			res.status       = ST_OK;
			res.slot_address = base_q + (32'(head_rd) << SLOT_SHIFT);
		end else if (ignored) begin
			res.status = ST_IGNORED;
		end else if (too_large) begin
			res.status = ST_TOO_LARGE;
		end else if (req_q.command == CMD_FREE) begin
			res.status = bad_addr ? ST_BAD_ADDR : ST_OK;
		end else if ((CUR_W+1)'(units) > (CUR_W+1)'(BLOCK_UNITS)) begin
			res.status = ST_TOO_LARGE;
		end else if (need_block && oom) begin
			res.status = ST_OOM;
		end else begin
			res.status       = ST_OK;
			res.slot_address = base_q + (32'(slot) << SLOT_SHIFT);
		end

		head_we    = free_go || cmd.pop;
		head_wdata = cmd.pop ? link_rd[UNIT_W-1:0] : free_unit;
		cur_we     = alloc_bump;
		cur_wdata  = need_block ? (arena_q + CUR_W'(units)) : cur_next[CUR_W-1:0];
	end

	scsa_ram #(.WIDTH(UNIT_W), .DEPTH(NUM_CLASSES)) u_head_ram (
		.clk   (clk),
		.we    (head_we),
		.waddr (cls_q),
		.wdata (head_wdata),
		.re    (cmd.accept),
		.raddr (cls_in),
		.rdata (head_rd)
	);

	scsa_ram #(.WIDTH(CUR_W), .DEPTH(NUM_CLASSES)) u_cursor_ram (
		.clk   (clk),
		.we    (cur_we),
		.waddr (cls_q),
		.wdata (cur_wdata),
		.re    (cmd.accept),
		.raddr (cls_in),
		.rdata (cur_rd)
	);

	scsa_ram #(.WIDTH(CUR_W), .DEPTH(NUM_CLASSES)) u_end_ram (
		.clk   (clk),
		.we    (alloc_new),
		.waddr (cls_q),
		.wdata (arena_next[CUR_W-1:0]),
		.re    (cmd.accept),
		.raddr (cls_in),
		.rdata (end_rd)
	);

	// link entry: next-valid bit over next unit index
	scsa_ram #(.WIDTH(LINK_W), .DEPTH(TOTAL_UNITS)) u_link_ram (
		.clk   (clk),
		.we    (free_go),
		.waddr (free_unit),
		.wdata ({ne, head_rd}),
		.re    (cmd.link_rd),
		.raddr (head_rd),
		.rdata (link_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q      <= ARENA_BASE_RESET;
			nonempty_q  <= '0;
			carved_q    <= '0;
			arena_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				base_q <= cfg_wdata;
			end
			if (free_go) begin
				nonempty_q[cls_q] <= 1'b1;
			end else if (cmd.pop) begin
				nonempty_q[cls_q] <= link_rd[LINK_W-1];
			end
			if (alloc_new) begin
				carved_q[cls_q] <= 1'b1;
				arena_q         <= arena_next[CUR_W-1:0];
			end
			if (cmd.take || cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q <= in_data;
			cls_q <= cls_in;
		end
		if (cmd.hold) begin
			res_q <= res;
		end
		if (cmd.take) begin
			out_q <= res;
		end else if (cmd.emit) begin
			out_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_pop_after_link: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> $past(cmd.link_rd))
		else $error("pop phase without a link read");

	a_arena_bound: assert property (@(posedge clk) disable iff (!arst_n)
		arena_q <= CUR_W'(TOTAL_UNITS))
		else $error("arena cursor beyond arena");

	a_fail_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.status != ST_OK) |-> out_q.slot_address == 32'd0)
		else $error("failed result carries an address");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.take || cmd.emit) |-> st.out_free)
		else $error("output overwritten before taken");

endmodule
`default_nettype wire

### hdl/size_class_slot_allocator_core.sv
// After the accepting edge a word passes the execute state and, for an allocate that pops a
//   free list, the pop state (link store read of the list head); its result then loads the
//   output register, or is parked until that register drains. A new word is taken only after
//   that load; one word may wait in the output register while the next one is worked on.
// Reset (arst_n low, asynchronous): lists empty, class blocks and arena cursor cleared,
//   arena_base set to 0x0001_0000. Head and link memories are not cleared.
`default_nettype none
module size_class_slot_allocator_core (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire scsa_pkg::scsa_in_t  in_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output scsa_pkg::scsa_out_t      out_data,
	input  wire logic                cfg_we,
	input  wire logic [31:0]         cfg_wdata
);
	import scsa_pkg::*;

	// Controller sequences each word: accept (class memories read), execute (decide and
	// write back the class state), optional pop (link read returns the next head), then
	// hand the result to the output register, or park it until that register drains.
	scsa_cmd_t  cmd;
	scsa_stat_t st;

	scsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	// Datapath holds the per-class head, cursor and block end memories, the link store,
	// the list and block valid bits, the arena cursor and the output register.
	scsa_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.st        (st),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire

### tb/tb_top.sv
`default_nettype none
module tb_top;
	import scsa_pkg::*;

	localparam int unsigned CYCLE_LIMIT       = 400000;
	localparam int unsigned DRAIN_HOLD_CYCLES = 200;
	localparam int unsigned ENDING_CYCLES     = 10;
	localparam int unsigned REPORT_LIMIT      = 10;

	// one request word together with the outcome it must produce
	typedef struct {
		scsa_in_t  req;
		scsa_out_t res;
	} request_entry_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	scsa_in_t    in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	scsa_out_t   out_data;
	logic        cfg_we = 1'b0;
	logic [31:0] cfg_wdata = '0;

	always #5 clk = ~clk;

	size_class_slot_allocator_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// ------------------------------------------------------------------
	// Allocator shadow: per-class LIFO lists, bump cursors, shared arena.
	// Everything is kept in slot units from the arena origin.
	// ------------------------------------------------------------------
	logic [31:0]       arena_origin = ARENA_BASE_RESET;
	logic [UNIT_W-1:0] list_top   [NUM_CLASSES];
	logic              list_live  [NUM_CLASSES];
	logic [CUR_W-1:0]  bump_next  [NUM_CLASSES];
	logic [CUR_W-1:0]  bump_limit [NUM_CLASSES];
	logic [CUR_W-1:0]  arena_next;
	logic [UNIT_W-1:0] chain_next [TOTAL_UNITS];
	logic              chain_live [TOTAL_UNITS];

	// slots handed out and not yet returned, used to build well-formed frees
	logic [UNIT_W-1:0] live_unit[$];
	int unsigned       live_cls[$];
	int unsigned       hot_class[6] = '{0, 1, 5, 20, 47, 63};

	request_entry_t requests_to_send[$];
	scsa_out_t      outcomes_due[$];
	request_entry_t on_offer;

	int unsigned tx_idle_pct = 17;
	int unsigned rx_idle_pct = 79;
	int unsigned drain_hold_left;
	int unsigned hold_requests = 0;
	int unsigned holds_served;
	int unsigned mismatch_count = 0;
	int unsigned cycle_count = 0;

	function automatic logic [31:0] unit_address(input int unsigned unit);
		return arena_origin + 32'(unit) * 32'(SLOT_BASE_BYTES);
	endfunction

	function automatic scsa_out_t outcome_of(input scsa_in_t req);
		scsa_out_t   res;
		int unsigned cls;
		int unsigned units;
		int unsigned unit;
		logic [31:0] offset;
		res.slot_address = '0;
		res.status = ST_OK;
		// null free and zero size are dropped before the size is looked at
		if (req.command == CMD_FREE && req.free_address == '0) begin
			res.status = ST_IGNORED;
		end else if (req.size_bytes == '0) begin
			res.status = ST_IGNORED;
		end else if (req.size_bytes > MAX_SIZE) begin
			res.status = ST_TOO_LARGE;
		end else begin
			cls = (int'(req.size_bytes) + SLOT_BASE_BYTES - 1) / SLOT_BASE_BYTES - 1;
			units = cls + 1;
			if (req.command == CMD_ALLOC) begin
				if (list_live[cls]) begin
					// pop the list head; the link store gives the next head
					unit = list_top[cls];
					list_top[cls] = chain_next[unit];
					list_live[cls] = chain_live[unit];
					res.slot_address = unit_address(unit);
				end else if (units > BLOCK_UNITS) begin
					res.status = ST_TOO_LARGE;
				end else if (bump_next[cls] + units > bump_limit[cls] &&
				             arena_next + BLOCK_UNITS > TOTAL_UNITS) begin
					res.status = ST_OOM;
				end else begin
					// carve a fresh block when the current one cannot hold the slot;
					// the old block's tail is abandoned
					if (bump_next[cls] + units > bump_limit[cls]) begin
						bump_next[cls] = arena_next;
						bump_limit[cls] = arena_next + BLOCK_UNITS;
						arena_next = arena_next + BLOCK_UNITS;
					end
					res.slot_address = unit_address(bump_next[cls]);
					bump_next[cls] = bump_next[cls] + units;
				end
			end else begin
				offset = req.free_address - arena_origin;
				if (req.free_address < arena_origin || offset >= ARENA_BYTES ||
				    offset % SLOT_BASE_BYTES != 0) begin
					res.status = ST_BAD_ADDR;
				end else begin
					// push without any ownership check
					unit = offset / SLOT_BASE_BYTES;
					chain_next[unit] = list_top[cls];
					chain_live[unit] = list_live[cls];
					list_top[cls] = UNIT_W'(unit);
					list_live[cls] = 1'b1;
				end
			end
		end
		return res;
	endfunction

	// Work out the outcome now, in order, and queue the word for the driver.
	task automatic offer(input logic cmd, input logic [15:0] size, input logic [31:0] addr);
		request_entry_t entry;
		entry.req.command = cmd;
		entry.req.size_bytes = size;
		entry.req.free_address = addr;
		entry.res = outcome_of(entry.req);
		if (cmd == CMD_ALLOC && entry.res.status == ST_OK) begin
			live_unit.push_back(UNIT_W'((entry.res.slot_address - arena_origin) >> SLOT_SHIFT));
			live_cls.push_back((int'(size) - 1) / SLOT_BASE_BYTES);
		end
		requests_to_send.push_back(entry);
	endtask

	// Mostly allocate/free pairs on a few classes (any class when all_classes is set), with noise mixed in.
	task automatic random_request(input bit all_classes);
		int unsigned pick;
		int unsigned cls;
		int unsigned idx;
		logic [15:0] size;
		pick = $urandom_range(99);
		if (all_classes) cls = $urandom_range(NUM_CLASSES - 1);
		else cls = hot_class[$urandom_range(5)];
		size = 16'(cls * SLOT_BASE_BYTES + $urandom_range(1, SLOT_BASE_BYTES));
		if (pick < 45 || (pick < 85 && live_unit.size() == 0)) begin
			offer(CMD_ALLOC, size, $urandom);
		end else if (pick < 85) begin
			idx = $urandom_range(live_unit.size() - 1);
			// most frees return the slot with a size of its own class
			if ($urandom_range(9) != 0)
				size = 16'(live_cls[idx] * SLOT_BASE_BYTES + $urandom_range(1, SLOT_BASE_BYTES));
			offer(CMD_FREE, size, unit_address(live_unit[idx]));
			live_unit.delete(idx);
			live_cls.delete(idx);
		end else if (pick < 90) begin
			if ($urandom_range(1) != 0) offer(CMD_FREE, size, '0);
			else offer(1'($urandom_range(1)), '0, $urandom);
		end else if (pick < 95) begin
			offer(1'($urandom_range(1)), 16'($urandom_range(MAX_SIZE + 1, 65535)), $urandom);
		end else if ($urandom_range(1) != 0) begin
			offer(CMD_FREE, size, $urandom);
		end else begin
			// inside the arena, aligned or not, owned or not
			offer(CMD_FREE, size, arena_origin + 32'($urandom_range(0, ARENA_BYTES - 1)));
		end
	endtask

	// Wait until the driver has nothing left and every outcome has been drained.
	task automatic wait_drained();
		do @(negedge clk);
		while (requests_to_send.size() != 0 || in_valid || outcomes_due.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_arena_base(input logic [31:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		arena_origin = value;
		@(negedge clk);
	endtask

	task automatic flag(input string what, input logic [31:0] want, input logic [31:0] got);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT)
			$display("mismatch on %s: expected %h, got %h", what, want, got);
	endtask

	// ------------------------------------------------------------------
	// Driver: present the next word, hold it until taken, idle at random.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else begin
			if (in_valid && in_ready)
				outcomes_due.push_back(on_offer.res);
			if (!in_valid || in_ready) begin
				if (requests_to_send.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
					on_offer = requests_to_send.pop_front();
					in_data <= on_offer.req;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off, counted here so the sender keeps pushing meanwhile.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drain_hold_left <= 0;
			holds_served <= 0;
		end else if (drain_hold_left != 0) begin
			drain_hold_left <= drain_hold_left - 1;
		end else if (holds_served != hold_requests) begin
			drain_hold_left <= DRAIN_HOLD_CYCLES;
			holds_served <= hold_requests;
		end
	end

	// ------------------------------------------------------------------
	// Monitor: compare each drained word with the oldest outcome due.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		scsa_out_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (outcomes_due.size() == 0) begin
					flag("unexpected word", '0, out_data.slot_address);
				end else begin
					want = outcomes_due.pop_front();
					if (out_data.slot_address !== want.slot_address)
						flag("slot_address", want.slot_address, out_data.slot_address);
					if (out_data.status !== want.status)
						flag("status", 32'(want.status), 32'(out_data.status));
				end
			end
			out_ready <= (drain_hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus sequence
	// ------------------------------------------------------------------
	initial begin
		for (int i = 0; i < NUM_CLASSES; i++) begin
			list_live[i] = 1'b0;
			bump_next[i] = '0;
			bump_limit[i] = '0;
		end
		arena_next = '0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed, origin at the low extreme.
		write_arena_base(32'd8);
		offer(CMD_ALLOC, 16'd0, 32'd0);             // zero size
		offer(CMD_FREE, 16'd0, 32'd16);             // zero size on free
		offer(CMD_FREE, 16'd8, 32'd0);              // null free
		offer(CMD_ALLOC, 16'(MAX_SIZE + 1), 32'd0); // one byte over the largest class
		offer(CMD_FREE, 16'hFFFF, 32'hFFFF_FFFF);   // oversized wins over the address
		offer(CMD_ALLOC, 16'd1, 32'd0);             // first slot of the arena
		offer(CMD_ALLOC, 16'd9, 32'd0);             // second class, second block
		offer(CMD_FREE, 16'd8, 32'd4);              // below the origin
		offer(CMD_FREE, 16'd8, 32'd8 + ARENA_BYTES);// past the arena end
		offer(CMD_FREE, 16'd8, 32'd11);             // misaligned
		offer(CMD_FREE, 16'd16, 32'd8);             // wrong size still pushed
		offer(CMD_ALLOC, 16'd16, 32'd0);            // pops it back
		offer(CMD_FREE, 16'd1, 32'd8);
		// largest class: eight slots per block, the ninth carves a new block
		repeat (9) offer(CMD_ALLOC, 16'(MAX_SIZE), 32'd0);
		wait_drained();

		// Zero origin: the slot at unit zero reads back as address zero.
		write_arena_base(32'd0);
		offer(CMD_ALLOC, 16'd8, 32'd0);
		wait_drained();

		// High extreme of the origin.
		write_arena_base(32'hFFFF_0000);
		offer(CMD_ALLOC, 16'd8, 32'd0);
		offer(CMD_FREE, 16'd8, 32'hFFFF_0010);
		offer(CMD_ALLOC, 16'd8, 32'd0);
		offer(CMD_FREE, 16'd8, 32'hFFFE_FFF8);
		offer(CMD_FREE, 16'd64, 32'hFFFF_FFF8);     // last unit of the arena
		offer(CMD_ALLOC, 16'd57, 32'd0);
		wait_drained();

		// Random, sender light and receiver heavy; pause the sender halfway.
		repeat (150) random_request(1'b0);
		wait_drained();
		repeat (150) random_request(1'b0);
		wait_drained();

		// Random origin, idling swapped.
		write_arena_base($urandom_range(8, 32'hFFFF_0000));
		tx_idle_pct = 79;
		rx_idle_pct = 17;
		repeat (300) random_request(1'b0);
		wait_drained();

		// Back to the reset origin, no idling, every class until the arena is spent.
		// Hold off the receiver with the queue full so the block backs up.
		write_arena_base(ARENA_BASE_RESET);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		repeat (300) random_request(1'b1);
		hold_requests++;
		wait_drained();

		repeat (ENDING_CYCLES) @(negedge clk);
		if (mismatch_count == 0 && outcomes_due.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
`default_nettype wire

### sim.f
hdl/scsa_pkg.sv
hdl/scsa_ram.sv
hdl/scsa_ctrl.sv
hdl/scsa_datapath.sv
hdl/size_class_slot_allocator_core.sv
tb/tb_top.sv
